[rtl/pore_pkg.sv]
// pore_pkg: shared widths, constants and reset values of the ratio estimator
// depends on nothing; imported by pore_div and the top level
package pore_pkg;

    localparam int unsigned QUO_BITS    = 17;
    localparam int unsigned RATIO_BITS  = 16;
    localparam int unsigned WLEN_BITS   = 16;
    localparam int unsigned LEVEL_BITS  = 19;
    localparam int unsigned CURVE_A_BITS = 11;
    localparam int unsigned CURVE_B_BITS = 10;
    localparam int unsigned PCT_BITS    = 7;
    localparam int unsigned ADDR_BITS   = 5;
    localparam int unsigned DATA_BITS   = 32;

    localparam int unsigned RATIO_SCALE = 1000;
    localparam int unsigned SCALE_BITS  = 10;
    localparam int unsigned PCT_ROUND   = 5;
    localparam int unsigned PCT_DIV     = 10;

    localparam logic [WLEN_BITS-1:0]    WLEN_RESET    = 16'd100;
    localparam logic [LEVEL_BITS-1:0]   DC_MIN_RESET  = 19'd15000;
    localparam logic [LEVEL_BITS-1:0]   AC_MIN_RESET  = 19'd100;
    localparam logic [CURVE_A_BITS-1:0] CURVE_A_RESET = 11'd1100;
    localparam logic [CURVE_B_BITS-1:0] CURVE_B_RESET = 10'd250;
    localparam logic [PCT_BITS-1:0]     PCT_LOW_RESET = 7'd70;
    localparam logic [PCT_BITS-1:0]     PCT_HIGH_RESET = 7'd100;

endpackage

[rtl/pore_mul.sv]
// pore_mul: shift-add multiplier, one multiplier bit per cycle, msb first
// standalone; instantiated by the ratio estimator top level
module pore_mul #(
    parameter int unsigned MC_W = 29,
    parameter int unsigned ML_W = 19
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [MC_W-1:0]      i_mcand,
    input  logic [ML_W-1:0]      i_mplier,
    output logic                 o_done,
    output logic [MC_W+ML_W-1:0] o_product
);

    localparam int unsigned P_W   = MC_W + ML_W;
    localparam int unsigned CNT_W = $clog2(ML_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [MC_W-1:0]  r_mc;
    logic [ML_W-1:0]  r_ml;
    logic [P_W-1:0]   r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(ML_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mc  <= i_mcand;
            r_ml  <= i_mplier;
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= {r_acc[P_W-2:0], 1'b0}
                     + (r_ml[ML_W-1] ? {{ML_W{1'b0}}, r_mc} : {P_W{1'b0}});
            r_ml  <= {r_ml[ML_W-2:0], 1'b0};
        end
    end

    assign o_done    = r_done;
    assign o_product = r_acc;

endmodule

[rtl/pore_div.sv]
// pore_div: restoring divider, one quotient bit per cycle, QUO_BITS bits
// depends on pore_pkg; instantiated by the ratio estimator top level
module pore_div
    import pore_pkg::*;
#(
    parameter int unsigned N_W = 48,
    parameter int unsigned D_W = 38
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [N_W-1:0]      i_num,
    input  logic [D_W-1:0]      i_den,
    output logic                o_done,
    output logic [QUO_BITS-1:0] o_quo
);

    localparam int unsigned X_W   = (N_W > D_W + QUO_BITS - 1) ? N_W : D_W + QUO_BITS - 1;
    localparam int unsigned CNT_W = $clog2(QUO_BITS + 1);

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [X_W-1:0]      r_rem;
    logic [X_W-1:0]      r_dsh;
    logic [QUO_BITS-1:0] r_quo;
    logic                w_ge;
    logic [X_W-1:0]      w_diff;

    assign w_ge   = r_rem >= r_dsh;
    assign w_diff = r_rem - r_dsh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(QUO_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= X_W'(i_num);
            r_dsh <= X_W'(i_den) << (QUO_BITS - 1);
            r_quo <= '0;
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem <= w_diff;
            end
            r_quo <= {r_quo[QUO_BITS-2:0], w_ge};
            r_dsh <= r_dsh >> 1;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

[rtl/pulse_oximetry_ratio_estimator_unit.sv]
// pulse_oximetry_ratio_estimator_unit: red/ir dc tracking, window swing and ratio of ratios
// depends on pore_pkg, pore_mul and pore_div
//
//  channel  | signals                                        | direction
//  ---------+------------------------------------------------+----------
//  input    | i_in_valid, o_in_ready, i_cmd, i_*_sample      | in
//  output   | o_out_valid, i_out_ready, result fields        | out
//  config   | psel, penable, pwrite, paddr, pwdata, prdata   | apb
//
// one beat at a time; a beat that closes the window passes through an extra close state
// a full ratio runs the serial multipliers (one bit per cycle) and three passes of
// the serial divider
// synchronous active-low reset; no clearing pass, state clears at once
// a finished result waits in the output register while the next beat is taken
module pulse_oximetry_ratio_estimator_unit
    import pore_pkg::*;
#(
    parameter int unsigned SAMPLE_BITS    = 19,
    parameter int unsigned DC_SHIFT_BITS  = 6,
    parameter int unsigned AVG_SHIFT_BITS = 2
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic                   i_cmd,
    input  logic [SAMPLE_BITS-1:0] i_red_sample,
    input  logic [SAMPLE_BITS-1:0] i_ir_sample,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic                   o_finger_present,
    output logic                   o_ratio_valid,
    output logic                   o_uncalibrated,
    output logic [RATIO_BITS-1:0]  o_ratio_scaled,
    output logic [PCT_BITS-1:0]    o_percent,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [ADDR_BITS-1:0]   paddr,
    input  logic [DATA_BITS-1:0]   pwdata,
    output logic [DATA_BITS-1:0]   prdata,
    output logic                   pready
);

    localparam int unsigned S      = SAMPLE_BITS;
    localparam int unsigned CMP_W  = (S > LEVEL_BITS) ? S : LEVEL_BITS;
    localparam int unsigned ML_W   = (S > RATIO_BITS) ? S : RATIO_BITS;
    localparam int unsigned MC_W   = S + SCALE_BITS;
    localparam int unsigned NUM_W  = MC_W + ML_W;
    localparam int unsigned DEN_W  = S + ML_W;
    localparam int unsigned T_W    = QUO_BITS + 1;

    typedef enum logic [2:0] {
        REG_WINDOW_LEN = 3'd0,
        REG_DC_MIN     = 3'd1,
        REG_AC_MIN     = 3'd2,
        REG_CURVE_A    = 3'd3,
        REG_CURVE_B    = 3'd4,
        REG_PCT_LOW    = 3'd5,
        REG_PCT_HIGH   = 3'd6
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FEED,
        ST_CLOSE,
        ST_CHECK,
        ST_MUL,
        ST_DIV1,
        ST_MUL2,
        ST_DIV2,
        ST_DIV3,
        ST_OUT
    } t_state;

    // configuration
    logic [WLEN_BITS-1:0]    r_window_len;
    logic [LEVEL_BITS-1:0]   r_dc_min;
    logic [LEVEL_BITS-1:0]   r_ac_min;
    logic [CURVE_A_BITS-1:0] r_curve_a;
    logic [CURVE_B_BITS-1:0] r_curve_b;
    logic [PCT_BITS-1:0]     r_pct_low;
    logic [PCT_BITS-1:0]     r_pct_high;
    t_reg_idx                w_reg_idx;

    // channel state, index 0 red, 1 infrared
    logic [S-1:0]         r_dc     [2];
    logic [S-1:0]         r_hi     [2];
    logic [S-1:0]         r_lo     [2];
    logic [S-1:0]         r_avg    [2];
    logic [S-1:0]         r_sample [2];
    logic                 r_primed;
    logic [WLEN_BITS-1:0] r_count;
    logic                 r_cmd;

    t_state               r_state;
    logic                 r_num_go;
    logic                 r_den_go;
    logic                 r_div_go;
    logic [MC_W-1:0]      r_mc_in;
    logic [ML_W-1:0]      r_ml_in;
    logic [NUM_W-1:0]     r_div_num;
    logic [DEN_W-1:0]     r_div_den;
    logic                 r_neg;

    logic                  r_res_finger;
    logic                  r_res_rvalid;
    logic [RATIO_BITS-1:0] r_res_ratio;
    logic [PCT_BITS-1:0]   r_res_pct;

    logic                  r_out_valid;
    logic                  r_out_finger;
    logic                  r_out_rvalid;
    logic [RATIO_BITS-1:0] r_out_ratio;
    logic [PCT_BITS-1:0]   r_out_pct;

    logic signed [S:0]    w_dc_diff  [2];
    logic signed [S:0]    w_dc_sum   [2];
    logic [S-1:0]         w_dc_new   [2];
    logic [S-1:0]         w_hi_new   [2];
    logic [S-1:0]         w_lo_new   [2];
    logic [S-1:0]         w_pp       [2];
    logic signed [S:0]    w_avg_diff [2];
    logic signed [S:0]    w_avg_sum  [2];
    logic [S-1:0]         w_avg_new  [2];
    logic [WLEN_BITS-1:0] w_cnt_inc;
    logic                 w_finger;
    logic                 w_ac_ok;
    logic [MC_W-1:0]      w_ar1000;

    logic                 w_num_done;
    logic                 w_den_done;
    logic                 w_div_done;
    logic [NUM_W-1:0]     w_num_prod;
    logic [DEN_W-1:0]     w_den_prod;
    logic [QUO_BITS-1:0]  w_quo;

    logic signed [T_W-1:0] w_t;
    logic signed [T_W-1:0] w_tneg;
    logic                  w_neg;
    logic [QUO_BITS-1:0]   w_mag;
    logic                  w_pct_ok;

    // apb register file
    assign pready    = 1'b1;
    assign w_reg_idx = t_reg_idx'(paddr[ADDR_BITS-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_len <= WLEN_RESET;
            r_dc_min     <= DC_MIN_RESET;
            r_ac_min     <= AC_MIN_RESET;
            r_curve_a    <= CURVE_A_RESET;
            r_curve_b    <= CURVE_B_RESET;
            r_pct_low    <= PCT_LOW_RESET;
            r_pct_high   <= PCT_HIGH_RESET;
        end else if (psel && penable && pwrite) begin
            case (w_reg_idx)
                REG_WINDOW_LEN: r_window_len <= pwdata[WLEN_BITS-1:0];
                REG_DC_MIN:     r_dc_min     <= pwdata[LEVEL_BITS-1:0];
                REG_AC_MIN:     r_ac_min     <= pwdata[LEVEL_BITS-1:0];
                REG_CURVE_A:    r_curve_a    <= pwdata[CURVE_A_BITS-1:0];
                REG_CURVE_B:    r_curve_b    <= pwdata[CURVE_B_BITS-1:0];
                REG_PCT_LOW:    r_pct_low    <= pwdata[PCT_BITS-1:0];
                REG_PCT_HIGH:   r_pct_high   <= pwdata[PCT_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            REG_WINDOW_LEN: prdata = DATA_BITS'(r_window_len);
            REG_DC_MIN:     prdata = DATA_BITS'(r_dc_min);
            REG_AC_MIN:     prdata = DATA_BITS'(r_ac_min);
            REG_CURVE_A:    prdata = DATA_BITS'(r_curve_a);
            REG_CURVE_B:    prdata = DATA_BITS'(r_curve_b);
            REG_PCT_LOW:    prdata = DATA_BITS'(r_pct_low);
            REG_PCT_HIGH:   prdata = DATA_BITS'(r_pct_high);
            default:        prdata = '0;
        endcase
    end

    // per channel dc tracking and window close
    always_comb begin
        for (int c = 0; c < 2; c++) begin
            w_dc_diff[c]  = $signed({1'b0, r_sample[c]}) - $signed({1'b0, r_dc[c]});
            w_dc_sum[c]   = $signed({1'b0, r_dc[c]}) + (w_dc_diff[c] >>> DC_SHIFT_BITS);
            w_dc_new[c]   = w_dc_sum[c][S-1:0];
            w_hi_new[c]   = (r_sample[c] > r_hi[c]) ? r_sample[c] : r_hi[c];
            w_lo_new[c]   = (r_sample[c] < r_lo[c]) ? r_sample[c] : r_lo[c];
            w_pp[c]       = r_hi[c] - r_lo[c];
            w_avg_diff[c] = $signed({1'b0, w_pp[c]}) - $signed({1'b0, r_avg[c]});
            w_avg_sum[c]  = $signed({1'b0, r_avg[c]}) + (w_avg_diff[c] >>> AVG_SHIFT_BITS);
            w_avg_new[c]  = (r_avg[c] == '0) ? w_pp[c] : w_avg_sum[c][S-1:0];
        end
    end

    assign w_cnt_inc = r_count + 1'b1;
    assign w_finger  = r_primed
                       && (CMP_W'(r_dc[0]) >= CMP_W'(r_dc_min))
                       && (CMP_W'(r_dc[1]) >= CMP_W'(r_dc_min));
    assign w_ac_ok   = (CMP_W'(r_avg[0]) >= CMP_W'(r_ac_min))
                       && (CMP_W'(r_avg[1]) >= CMP_W'(r_ac_min));
    // x1000 = x1024 - x16 - x8
    assign w_ar1000  = (MC_W'(r_avg[0]) << SCALE_BITS) - (MC_W'(r_avg[0]) << 4)
                       - (MC_W'(r_avg[0]) << 3);

    // percent rounding
    assign w_t    = $signed(T_W'(r_curve_a) + T_W'(PCT_ROUND)) - $signed({1'b0, w_quo});
    assign w_tneg = -w_t;
    assign w_neg  = w_t[T_W-1];
    assign w_mag  = w_neg ? w_tneg[QUO_BITS-1:0] : w_t[QUO_BITS-1:0];
    assign w_pct_ok = !(r_neg && (w_quo != '0))
                      && (w_quo >= QUO_BITS'(r_pct_low))
                      && (w_quo <= QUO_BITS'(r_pct_high));

    pore_mul #(
        .MC_W (MC_W),
        .ML_W (ML_W)
    ) u_mul_num (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_num_go),
        .i_mcand   (r_mc_in),
        .i_mplier  (r_ml_in),
        .o_done    (w_num_done),
        .o_product (w_num_prod)
    );

    pore_mul #(
        .MC_W (S),
        .ML_W (ML_W)
    ) u_mul_den (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_den_go),
        .i_mcand   (r_dc[0]),
        .i_mplier  (ML_W'(r_avg[1])),
        .o_done    (w_den_done),
        .o_product (w_den_prod)
    );

    pore_div #(
        .N_W (NUM_W),
        .D_W (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_num   (r_div_num),
        .i_den   (r_div_den),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    assign o_in_ready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_num_go    <= 1'b0;
            r_den_go    <= 1'b0;
            r_div_go    <= 1'b0;
            r_out_valid <= 1'b0;
            r_primed    <= 1'b0;
            r_count     <= '0;
            for (int c = 0; c < 2; c++) begin
                r_dc[c]  <= '0;
                r_hi[c]  <= '0;
                r_lo[c]  <= '0;
                r_avg[c] <= '0;
            end
        end else begin
            r_num_go <= 1'b0;
            r_den_go <= 1'b0;
            r_div_go <= 1'b0;
            if (r_out_valid && i_out_ready && (r_state != ST_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_cmd       <= i_cmd;
                        r_sample[0] <= i_red_sample;
                        r_sample[1] <= i_ir_sample;
                        r_state     <= ST_FEED;
                    end
                end
                ST_FEED: begin
                    if (r_cmd) begin
                        r_primed <= 1'b0;
                        r_count  <= '0;
                        for (int c = 0; c < 2; c++) begin
                            r_dc[c]  <= '0;
                            r_hi[c]  <= '0;
                            r_lo[c]  <= '0;
                            r_avg[c] <= '0;
                        end
                        r_state <= ST_CHECK;
                    end else begin
                        for (int c = 0; c < 2; c++) begin
                            r_dc[c] <= r_primed ? w_dc_new[c] : r_sample[c];
                            r_hi[c] <= r_primed ? w_hi_new[c] : r_sample[c];
                            r_lo[c] <= r_primed ? w_lo_new[c] : r_sample[c];
                        end
                        r_primed <= 1'b1;
                        if (w_cnt_inc >= r_window_len) begin
                            r_count <= '0;
                            r_state <= ST_CLOSE;
                        end else begin
                            r_count <= w_cnt_inc;
                            r_state <= ST_CHECK;
                        end
                    end
                end
                ST_CLOSE: begin
                    for (int c = 0; c < 2; c++) begin
                        r_avg[c] <= w_avg_new[c];
                        r_hi[c]  <= r_dc[c];
                        r_lo[c]  <= r_dc[c];
                    end
                    r_state <= ST_CHECK;
                end
                ST_CHECK: begin
                    r_res_finger <= w_finger;
                    r_res_rvalid <= 1'b0;
                    r_res_ratio  <= '0;
                    r_res_pct    <= '0;
                    if (w_finger && w_ac_ok) begin
                        r_mc_in  <= w_ar1000;
                        r_ml_in  <= ML_W'(r_dc[1]);
                        r_num_go <= 1'b1;
                        r_den_go <= 1'b1;
                        r_state  <= ST_MUL;
                    end else begin
                        r_state <= ST_OUT;
                    end
                end
                ST_MUL: begin
                    if (w_num_done && w_den_done) begin
                        if (w_den_prod == '0) begin
                            r_state <= ST_OUT;
                        end else begin
                            r_div_num <= w_num_prod;
                            r_div_den <= w_den_prod;
                            r_div_go  <= 1'b1;
                            r_state   <= ST_DIV1;
                        end
                    end
                end
                ST_DIV1: begin
                    if (w_div_done) begin
                        if ((w_quo == '0) || w_quo[QUO_BITS-1]) begin
                            r_state <= ST_OUT;
                        end else begin
                            r_res_ratio <= w_quo[RATIO_BITS-1:0];
                            r_mc_in     <= MC_W'(r_curve_b);
                            r_ml_in     <= ML_W'(w_quo[RATIO_BITS-1:0]);
                            r_num_go    <= 1'b1;
                            r_state     <= ST_MUL2;
                        end
                    end
                end
                ST_MUL2: begin
                    if (w_num_done) begin
                        r_div_num <= w_num_prod;
                        r_div_den <= DEN_W'(RATIO_SCALE);
                        r_div_go  <= 1'b1;
                        r_state   <= ST_DIV2;
                    end
                end
                ST_DIV2: begin
                    if (w_div_done) begin
                        r_neg     <= w_neg;
                        r_div_num <= NUM_W'(w_mag);
                        r_div_den <= DEN_W'(PCT_DIV);
                        r_div_go  <= 1'b1;
                        r_state   <= ST_DIV3;
                    end
                end
                ST_DIV3: begin
                    if (w_div_done) begin
                        r_res_rvalid <= 1'b1;
                        r_res_pct    <= w_pct_ok ? w_quo[PCT_BITS-1:0] : '0;
                        r_state      <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_finger <= r_res_finger;
                        r_out_rvalid <= r_res_rvalid;
                        r_out_ratio  <= r_res_ratio;
                        r_out_pct    <= r_res_pct;
                        r_state      <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_finger_present = r_out_finger;
    assign o_ratio_valid    = r_out_rvalid;
    assign o_uncalibrated   = 1'b1;
    assign o_ratio_scaled   = r_out_ratio;
    assign o_percent        = r_out_pct;

`ifndef SYNTHESIS
    a_one_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second beat taken while one is in work");

    a_ratio_needs_finger: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_ratio_valid) |-> (o_finger_present && (o_ratio_scaled != '0)))
        else $error("ratio reported without finger or with zero value");

    a_no_ratio_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_ratio_valid) |-> ((o_ratio_scaled == '0) && (o_percent == '0)))
        else $error("ratio or percent nonzero without a valid ratio");

    a_window_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hi[0] >= r_lo[0]) && (r_hi[1] >= r_lo[1]))
        else $error("window high below window low");

    a_pct_limits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_percent != '0)) |-> ((o_percent >= r_pct_low)
                                                && (o_percent <= r_pct_high)))
        else $error("percent outside limits");
`endif

endmodule
